### rtl/rgbled_pkg.sv
`timescale 1ns / 1ps

package rgbled_pkg;

  localparam int unsigned MAX_LEDS_DEF    = 64;
  localparam int unsigned BITS_PER_LED    = 24;
  localparam int unsigned RESET_SLOTS_MAX = 255;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam int unsigned PERIOD_W = 17;
  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned RSLOT_W  = 8;
  localparam int unsigned LEDCNT_W = 7;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned PIXEL_W  = 24;

  localparam logic [PERIOD_W-1:0] PERIOD_MIN = PERIOD_W'(2);
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = PERIOD_W'(65536);

  localparam logic [PERIOD_W-1:0] PERIOD_RST   = PERIOD_W'(60);
  localparam logic [DUTY_W-1:0]   ONE_HIGH_RST = DUTY_W'(34);
  localparam logic [DUTY_W-1:0]   ZERO_HIGH_RST = DUTY_W'(17);
  localparam logic [RSLOT_W-1:0]  RSLOTS_RST   = RSLOT_W'(40);
  localparam logic [LEDCNT_W-1:0] LEDCNT_RST   = LEDCNT_W'(1);

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_START = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD    = 3'd0,
    CFG_ONE_HIGH  = 3'd1,
    CFG_ZERO_HIGH = 3'd2,
    CFG_RSLOTS    = 3'd3,
    CFG_LEDCNT    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
  } result_t;

endpackage

### rtl/rgbled_stream_if.sv
`timescale 1ns / 1ps

interface rgbled_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/rgb_led_chain_pwm_sender.sv
`timescale 1ns / 1ps

// One-wire RGB LED chain sender. Every transaction on items is one clock tick, a pixel
// write, a frame start or an unused mode that does nothing, and yields exactly one
// transaction on results that reports the line level, the busy flag and the frame-done
// pulse after that item. The block takes one transaction per clock cycle while results
// are taken and the memory is not being cleared; a taken item passes the registered read
// of the pixel memory and the output register before its result is valid. After reset the
// pixel memory is cleared one entry per cycle, so items is not ready until every entry
// is cleared; configuration writes are taken at once. Configuration must only be written
// while all results have been taken; a write acts at once, also on a frame being sent.
module rgb_led_chain_pwm_sender #(
  parameter int unsigned MAX_LEDS = rgbled_pkg::MAX_LEDS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  rgbled_stream_if.sink                      items,
  rgbled_stream_if.source                    results,
  input  logic                               cfg_we,
  input  logic [rgbled_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rgbled_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import rgbled_pkg::*;

  localparam int unsigned ADDR_W     = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int unsigned LEDC_W     = $clog2(MAX_LEDS + 1);
  localparam int unsigned SLOT_W     = $clog2(RESET_SLOTS_MAX + MAX_LEDS * BITS_PER_LED + 1);
  localparam int unsigned PROD_W     = SLOT_W + 5;
  localparam int unsigned LED_SEL_W  = SLOT_W - 4;
  localparam int unsigned DIV3_MUL   = 171;
  localparam int unsigned DIV3_SHIFT = 9;

  logic [PERIOD_W-1:0] period_ticks;
  logic [DUTY_W-1:0]   one_high_ticks;
  logic [DUTY_W-1:0]   zero_high_ticks;
  logic [RSLOT_W-1:0]  reset_slots;
  logic [LEDCNT_W-1:0] led_total;

  logic                sending, sending_next;
  logic [SLOT_W-1:0]   slot_counter, slot_counter_next;
  logic [TICK_W-1:0]   tick_counter, tick_counter_next;
  logic                done_next;

  logic                clr_active;
  logic [ADDR_W-1:0]   clr_addr;

  logic                s1_valid;
  logic                s1_data;
  logic                s1_busy;
  logic                s1_done;
  logic [TICK_W-1:0]   s1_tick;
  logic [POS_W-1:0]    s1_pos;

  logic                out_valid;
  result_t             out_reg;
  result_t             s1_result;

  logic [PERIOD_W-1:0] eff_period;
  logic [LEDC_W-1:0]   eff_leds;
  logic [SLOT_W-1:0]   frame_slots;
  logic [SLOT_W-1:0]   rslots_ext;
  logic [PERIOD_W-1:0] tick_inc;
  logic [SLOT_W-1:0]   slot_inc;

  logic [SLOT_W-1:0]    data_slot;
  logic [PROD_W-1:0]    led_prod;
  logic [LED_SEL_W-1:0] led_sel;
  logic [POS_W-1:0]     pos_sel;
  logic                 in_data;

  logic                out_load;
  logic                accept;
  mode_t               mode;
  logic [10:0]         idx_ext;
  logic                pix_write;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [PIXEL_W-1:0]  ram_wdata;
  logic [PIXEL_W-1:0]  ram_q;
  logic                pix_bit;
  logic [DUTY_W-1:0]   duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks    <= PERIOD_RST;
      one_high_ticks  <= ONE_HIGH_RST;
      zero_high_ticks <= ZERO_HIGH_RST;
      reset_slots     <= RSLOTS_RST;
      led_total       <= LEDCNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PERIOD:    period_ticks    <= cfg_data[PERIOD_W-1:0];
        CFG_ONE_HIGH:  one_high_ticks  <= cfg_data[DUTY_W-1:0];
        CFG_ZERO_HIGH: zero_high_ticks <= cfg_data[DUTY_W-1:0];
        CFG_RSLOTS:    reset_slots     <= cfg_data[RSLOT_W-1:0];
        CFG_LEDCNT:    led_total       <= cfg_data[LEDCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (period_ticks < PERIOD_MIN) begin
      eff_period = PERIOD_MIN;
    end else if (period_ticks > PERIOD_MAX) begin
      eff_period = PERIOD_MAX;
    end else begin
      eff_period = period_ticks;
    end
    if (led_total == '0) begin
      eff_leds = LEDC_W'(1);
    end else if (32'(led_total) > MAX_LEDS) begin
      eff_leds = LEDC_W'(MAX_LEDS);
    end else begin
      eff_leds = LEDC_W'(led_total);
    end
  end

  assign rslots_ext  = SLOT_W'(reset_slots);
  assign frame_slots = rslots_ext + (SLOT_W'(eff_leds) << 4) + (SLOT_W'(eff_leds) << 3);
  assign tick_inc    = PERIOD_W'(tick_counter) + PERIOD_W'(1);
  assign slot_inc    = slot_counter + SLOT_W'(1);

  assign out_load    = s1_valid && (!out_valid || results.ready);
  assign items.ready = !clr_active && (!s1_valid || out_load);
  assign accept      = items.valid && items.ready;
  assign mode        = mode_t'(items.data.mode);
  assign idx_ext     = {5'b0, items.data.pixel_index};
  assign pix_write   = accept && (mode == MODE_WRITE) && !sending &&
                       (32'(idx_ext) < MAX_LEDS);

  always_comb begin
    sending_next      = sending;
    slot_counter_next = slot_counter;
    tick_counter_next = tick_counter;
    done_next         = 1'b0;
    if (accept) begin
      case (mode)
        MODE_TICK: begin
          if (sending) begin
            tick_counter_next = tick_inc[TICK_W-1:0];
            if (tick_inc >= eff_period) begin
              tick_counter_next = '0;
              slot_counter_next = slot_inc;
              if (slot_inc >= frame_slots) begin
                sending_next      = 1'b0;
                slot_counter_next = '0;
                done_next         = 1'b1;
              end
            end
          end
        end
        MODE_START: begin
          if (!sending) begin
            sending_next      = 1'b1;
            slot_counter_next = '0;
            tick_counter_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // The LED is the data slot divided by 24: a shift by three, then a division by three
  // as a product by 171 over 512, which is exact for every slot a frame can reach.
  assign data_slot = slot_counter_next - rslots_ext;
  assign led_prod  = PROD_W'(data_slot[SLOT_W-1:3]) * PROD_W'(DIV3_MUL);
  assign led_sel   = led_prod[PROD_W-1:DIV3_SHIFT];
  assign pos_sel   = data_slot[POS_W-1:0] -
                     ((POS_W'(led_sel) << 4) + (POS_W'(led_sel) << 3));
  assign in_data   = sending_next && (slot_counter_next >= rslots_ext) &&
                     (SLOT_W'(led_sel) < SLOT_W'(eff_leds));

  always_ff @(posedge clk) begin
    if (rst) begin
      sending      <= 1'b0;
      slot_counter <= '0;
      tick_counter <= '0;
    end else begin
      sending      <= sending_next;
      slot_counter <= slot_counter_next;
      tick_counter <= tick_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(MAX_LEDS - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  assign ram_we    = clr_active || pix_write;
  assign ram_waddr = clr_active ? clr_addr : idx_ext[ADDR_W-1:0];
  assign ram_wdata = clr_active ? '0 :
                     {items.data.green, items.data.red, items.data.blue};

  rgbled_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_LEDS)
  ) u_pixel_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (led_sel[ADDR_W-1:0]),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data <= in_data;
      s1_busy <= sending_next;
      s1_done <= done_next;
      s1_tick <= tick_counter_next;
      s1_pos  <= pos_sel;
    end
  end

  assign pix_bit = ram_q[POS_W'(BITS_PER_LED - 1) - s1_pos];
  assign duty    = pix_bit ? one_high_ticks : zero_high_ticks;

  always_comb begin
    s1_result.line_level = s1_data && (s1_tick < duty);
    s1_result.busy_res   = s1_busy;
    s1_result.frame_done = s1_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reg <= s1_result;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_reg;

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !items.ready)
    else $error("item taken during memory clear");

  a_no_pixel_write_while_sending: assert property (@(posedge clk) disable iff (rst)
    (ram_we && !clr_active) |-> !sending)
    else $error("pixel memory written during a frame");

  a_idle_slot_zero: assert property (@(posedge clk) disable iff (rst)
    !sending |-> (slot_counter == '0))
    else $error("slot counter not cleared while idle");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_done) |-> !s1_busy)
    else $error("frame end reported while still busy");

endmodule

### rtl/rgbled_ram.sv
`timescale 1ns / 1ps

module rgbled_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### dv/rgb_led_chain_pwm_sender_checker.sv
`timescale 1ns / 1ps

module led_frame_checker
  import rgbled_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_ready,
  input  item_t                 item_data,
  input  logic                  result_valid,
  input  logic                  result_ready,
  input  result_t               result_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output logic                  frame_active
);

  logic [PIXEL_W-1:0]  led_colors [MAX_LEDS_DEF];
  logic [10:0]         slot_pos;
  logic [PERIOD_W-1:0] tick_pos;
  logic                sending_now;

  logic [PERIOD_W-1:0] slot_period;
  logic [DUTY_W-1:0]   one_duty;
  logic [DUTY_W-1:0]   zero_duty;
  logic [RSLOT_W-1:0]  lead_slots;
  logic [LEDCNT_W-1:0] chain_leds;

  result_t expected_levels[$];
  int      mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [PERIOD_W-1:0] slot_ticks();
    if (slot_period < PERIOD_MIN) return PERIOD_MIN;
    if (slot_period > PERIOD_MAX) return PERIOD_MAX;
    return slot_period;
  endfunction

  function automatic int leds_in_frame();
    if (chain_leds == 0) return 1;
    if (chain_leds > MAX_LEDS_DEF) return MAX_LEDS_DEF;
    return int'(chain_leds);
  endfunction

  function automatic int frame_length();
    return int'(lead_slots) + leds_in_frame() * BITS_PER_LED;
  endfunction

  function automatic logic line_now();
    int              bit_no;
    int              led;
    int              pos;
    logic [DUTY_W-1:0] duty;
    if (!sending_now || slot_pos < lead_slots) return 1'b0;
    bit_no = int'(slot_pos) - int'(lead_slots);
    led = bit_no / BITS_PER_LED;
    pos = bit_no % BITS_PER_LED;
    if (led >= leds_in_frame()) return 1'b0;
    duty = led_colors[led][PIXEL_W-1-pos] ? one_duty : zero_duty;
    return tick_pos < {1'b0, duty};
  endfunction

  function automatic result_t next_line_state(input item_t it);
    result_t r;
    r.frame_done = 1'b0;
    case (it.mode)
      MODE_TICK: begin
        if (sending_now) begin
          tick_pos = tick_pos + 1'b1;
          if (tick_pos >= slot_ticks()) begin
            tick_pos = '0;
            slot_pos = slot_pos + 1'b1;
            if (int'(slot_pos) >= frame_length()) begin
              sending_now = 1'b0;
              slot_pos = '0;
              r.frame_done = 1'b1;
            end
          end
        end
      end
      MODE_WRITE: begin
        if (!sending_now) led_colors[it.pixel_index] = {it.green, it.red, it.blue};
      end
      MODE_START: begin
        if (!sending_now) begin
          sending_now = 1'b1;
          slot_pos = '0;
          tick_pos = '0;
        end
      end
      default: ;
    endcase
    r.line_level = line_now();
    r.busy_res = sending_now;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      foreach (led_colors[i]) led_colors[i] = '0;
      slot_pos = '0;
      tick_pos = '0;
      sending_now = 1'b0;
      slot_period = PERIOD_RST;
      one_duty = ONE_HIGH_RST;
      zero_duty = ZERO_HIGH_RST;
      lead_slots = RSLOTS_RST;
      chain_leds = LEDCNT_RST;
      expected_levels.delete();
      pending <= 0;
      frame_active <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_PERIOD:    slot_period = cfg_data[PERIOD_W-1:0];
          CFG_ONE_HIGH:  one_duty = cfg_data[DUTY_W-1:0];
          CFG_ZERO_HIGH: zero_duty = cfg_data[DUTY_W-1:0];
          CFG_RSLOTS:    lead_slots = cfg_data[RSLOT_W-1:0];
          CFG_LEDCNT:    chain_leds = cfg_data[LEDCNT_W-1:0];
          default: ;
        endcase
      end
      if (item_valid && item_ready) expected_levels.push_back(next_line_state(item_data));
      if (result_valid && result_ready) begin
        if (expected_levels.size() == 0) begin
          $error("Result transaction arrived with no expectation waiting.");
          mismatches++;
        end else begin
          want = expected_levels.pop_front();
          if (result_data.line_level !== want.line_level) begin
            $error("line_level: expected %0d, actual %0d", want.line_level,
                   result_data.line_level);
            mismatches++;
          end
          if (result_data.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d, actual %0d", want.busy_res, result_data.busy_res);
            mismatches++;
          end
          if (result_data.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0d, actual %0d", want.frame_done,
                   result_data.frame_done);
            mismatches++;
          end
        end
      end
      pending <= expected_levels.size();
      frame_active <= sending_now;
    end
  end

endmodule

### dv/rgb_led_chain_pwm_sender_test.sv
`timescale 1ns / 1ps

module rgb_led_chain_pwm_sender_test;
  import rgbled_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         ITEM_TARGET = 800;
  localparam int         HOLD_CYCLES = 400;
  localparam int         IDLE_PCT    = 11;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  calm = 1'b0;
  logic                  hold_req = 1'b0;
  int                    fail_count;
  int                    pending;
  logic                  frame_active;
  int                    content_items = 0;

  rgbled_stream_if #(.payload_t(item_t))   items ();
  rgbled_stream_if #(.payload_t(result_t)) results ();

  rgb_led_chain_pwm_sender u_dut (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .results   (results),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  led_frame_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (items.valid),
    .item_ready   (items.ready),
    .item_data    (items.data),
    .result_valid (results.valid),
    .result_ready (results.ready),
    .result_data  (results.data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .frame_active (frame_active)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // The receiver stalls at random, except in the calm phase, and holds off once for a long
  // stretch so that the block backs up and stops taking transactions.
  initial begin : result_sink
    logic hold_taken;
    hold_taken = 1'b0;
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        results.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        results.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic item_t make_item(input logic [1:0] mode);
    item_t it;
    it.mode = mode;
    it.pixel_index = 6'($urandom);
    it.red = 8'($urandom);
    it.green = 8'($urandom);
    it.blue = 8'($urandom);
    return it;
  endfunction

  function automatic item_t pixel_item(input logic [5:0] idx, input logic [7:0] r,
                                       input logic [7:0] g, input logic [7:0] b);
    item_t it;
    it.mode = MODE_WRITE;
    it.pixel_index = idx;
    it.red = r;
    it.green = g;
    it.blue = b;
    return it;
  endfunction

  function automatic item_t noise_item();
    logic [1:0] pick;
    pick = 2'($urandom_range(0, 2));
    case (pick)
      2'd0:    return make_item(MODE_WRITE);
      2'd1:    return make_item(MODE_START);
      default: return make_item(MODE_UNUSED);
    endcase
  endfunction

  task automatic send(input item_t it);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      items.valid <= 1'b0;
      @(posedge clk);
    end
    items.valid <= 1'b1;
    items.data <= it;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
    content_items++;
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send(make_item(MODE_TICK));
  endtask

  // Holds the input idle until every expected result has been taken.
  task automatic drain();
    items.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Ticks the running frame to its end, mixing in noise items at the given percentage, then
  // waits with the input idle until every expected result has been taken.
  task automatic run_out_frame(input int noise_pct);
    forever begin
      if (frame_active) begin
        if ($urandom_range(99) < noise_pct) begin
          send(noise_item());
        end else begin
          send(make_item(MODE_TICK));
        end
      end else begin
        items.valid <= 1'b0;
        @(posedge clk);
        if (!frame_active && pending == 0) break;
      end
    end
  endtask

  task automatic program_regs(input logic [16:0] period, input logic [15:0] one_high,
                              input logic [15:0] zero_high, input logic [7:0] lead,
                              input logic [6:0] leds);
    cfg_we <= 1'b1;
    cfg_index <= CFG_PERIOD;
    cfg_data <= period;
    @(posedge clk);
    cfg_index <= CFG_ONE_HIGH;
    cfg_data <= CFG_DATA_W'(one_high);
    @(posedge clk);
    cfg_index <= CFG_ZERO_HIGH;
    cfg_data <= CFG_DATA_W'(zero_high);
    @(posedge clk);
    cfg_index <= CFG_RSLOTS;
    cfg_data <= CFG_DATA_W'(lead);
    @(posedge clk);
    cfg_index <= CFG_LEDCNT;
    cfg_data <= CFG_DATA_W'(leds);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    item_t       it;
    int          phase_no;
    int          n_leds;
    logic [16:0] period;
    logic [15:0] one_high;
    logic [15:0] zero_high;
    logic [7:0]  lead;
    logic [6:0]  leds;

    items.valid <= 1'b0;
    items.data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: idle items, pixel extremes, then one frame with busy traffic ignored.
    // After the first reset slot the frame is shortened while it runs.
    it = make_item(MODE_UNUSED);
    it.pixel_index = '1;
    it.red = '1;
    it.green = '1;
    it.blue = '1;
    send(it);
    send(make_item(MODE_TICK));
    send(pixel_item(6'd0, 8'h00, 8'hFF, 8'h81));
    send(pixel_item(6'd63, 8'hFF, 8'hFF, 8'hFF));
    send(make_item(MODE_START));
    send(pixel_item(6'd0, 8'hFF, 8'h00, 8'h00));
    send(make_item(MODE_START));
    send(make_item(MODE_UNUSED));
    send_ticks(60);
    drain();
    program_regs(17'd4, 16'd3, 16'd1, 8'd0, 7'd1);
    run_out_frame(0);

    // Period below the minimum, one duty over the period, zero duty of zero, no lead slots.
    program_regs(17'd0, 16'hFFFF, 16'h0000, 8'd0, 7'd0);
    send(pixel_item(6'd0, 8'hA5, 8'h3C, 8'h0F));
    send(make_item(MODE_START));
    run_out_frame(0);

    // Longest lead, cut short while the frame runs.
    program_regs(17'd1, 16'd1, 16'd0, 8'd255, 7'd2);
    send(pixel_item(6'd1, 8'h5A, 8'hC3, 8'hF0));
    send(make_item(MODE_START));
    send_ticks(10);
    drain();
    program_regs(17'd1, 16'd1, 16'd0, 8'd0, 7'd2);
    run_out_frame(0);

    // Full chain, with a count above the store size, then shrunk below the current slot.
    program_regs(17'd3, 16'd2, 16'd1, 8'd1, 7'd127);
    for (int i = 0; i < MAX_LEDS_DEF; i++) begin
      it = make_item(MODE_WRITE);
      it.pixel_index = 6'(i);
      send(it);
    end
    send(make_item(MODE_START));
    send_ticks(90);
    drain();
    program_regs(17'd3, 16'd2, 16'd1, 8'd1, 7'd0);
    run_out_frame(0);

    // Longest periods leave no room for a frame, so only idle traffic runs here.
    program_regs(17'h1FFFF, 16'hFFFF, 16'hFFFF, 8'd0, 7'd64);
    send(make_item(MODE_TICK));
    send(make_item(MODE_UNUSED));
    send(make_item(MODE_WRITE));
    run_out_frame(0);
    program_regs(17'd65536, 16'd0, 16'd0, 8'd0, 7'd1);
    send(make_item(MODE_TICK));
    send(make_item(MODE_WRITE));
    run_out_frame(0);

    phase_no = 0;
    while (content_items < ITEM_TARGET || phase_no < 2) begin
      phase_no++;
      hold_req <= 1'b1;
      calm <= (phase_no == 2);
      case ($urandom_range(0, 9))
        0:       period = 17'($urandom_range(0, 1));
        1, 2:    period = 17'($urandom_range(5, 7));
        default: period = 17'($urandom_range(2, 4));
      endcase
      one_high = ($urandom_range(9) == 0) ? 16'($urandom) :
                 16'($urandom_range(0, int'(period) + 1));
      zero_high = ($urandom_range(9) == 0) ? 16'($urandom) :
                  16'($urandom_range(0, int'(period) + 1));
      lead = ($urandom_range(4) == 0) ? 8'($urandom_range(4, 12)) :
             8'($urandom_range(0, 3));
      case ($urandom_range(0, 19))
        0:       leds = 7'd0;
        1, 2:    leds = 7'($urandom_range(3, 4));
        default: leds = 7'($urandom_range(1, 2));
      endcase
      n_leds = (leds == 0) ? 1 : int'(leds);
      program_regs(period, one_high, zero_high, lead, leds);
      repeat ($urandom_range(1, 2)) begin
        repeat ($urandom_range(0, n_leds + 2)) begin
          if ($urandom_range(99) < 10) begin
            send(($urandom_range(1) == 0) ? make_item(MODE_TICK) : make_item(MODE_UNUSED));
          end else begin
            it = make_item(MODE_WRITE);
            if ($urandom_range(3) != 0) it.pixel_index = 6'($urandom_range(0, n_leds - 1));
            send(it);
          end
        end
        send(make_item(MODE_START));
        run_out_frame(8);
      end
    end
    calm <= 1'b0;

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
